// ===== hw/rtl/tgsp_pkg.sv =====
`default_nettype none

package tgsp_pkg;

  localparam int DEF_MAX_SIDE  = 256;
  localparam int DEF_MAX_PARTS = 16;
  localparam int DEF_CELL_BITS = 16;

  localparam int REG_BITS   = 9;
  localparam int COORD_BITS = 17;
  localparam int WRAP_STEP  = 2;

  localparam logic [REG_BITS-1:0] SIDE_RESET = 9'd256;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LAND  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tgsp_ram.sv =====
`default_nettype none

module tgsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tgsp_wrap.sv =====
`default_nettype none

module tgsp_wrap #(
  parameter int SIDE_BITS = 9
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic signed [tgsp_pkg::COORD_BITS-1:0] value,
  input  wire logic [SIDE_BITS-1:0]                   side,
  output logic                                        done,
  output logic [SIDE_BITS-1:0]                        result
);

  localparam int CYCLES   = (tgsp_pkg::COORD_BITS + tgsp_pkg::WRAP_STEP - 1) /
                            tgsp_pkg::WRAP_STEP;
  localparam int MAG_BITS = CYCLES * tgsp_pkg::WRAP_STEP;
  localparam int CNT_BITS = (CYCLES > 1) ? $clog2(CYCLES) : 1;

  logic                                busy;
  logic [CNT_BITS-1:0]                 cnt;
  logic                                neg;
  logic [MAG_BITS-1:0]                 mag;
  logic [SIDE_BITS-1:0]                rem;
  logic [SIDE_BITS-1:0]                side_q;
  logic [MAG_BITS-1:0]                 mag_next;
  logic [SIDE_BITS-1:0]                rem_next;
  logic [tgsp_pkg::COORD_BITS-1:0]     abs_value;

  assign abs_value = value[tgsp_pkg::COORD_BITS-1] ? -value : value;

  always_comb begin
    logic [SIDE_BITS:0]   t;
    logic [SIDE_BITS-1:0] r;
    logic [MAG_BITS-1:0]  m;
    r = rem;
    m = mag;
    for (int k = 0; k < tgsp_pkg::WRAP_STEP; k++) begin
      t = {r, m[MAG_BITS-1]};
      if (t >= {1'b0, side_q}) begin
        t = t - {1'b0, side_q};
      end
      r = t[SIDE_BITS-1:0];
      m = {m[MAG_BITS-2:0], 1'b0};
    end
    rem_next = r;
    mag_next = m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg    <= value[tgsp_pkg::COORD_BITS-1];
      mag    <= MAG_BITS'(abs_value);
      rem    <= '0;
      side_q <= side;
    end else if (busy) begin
      mag <= mag_next;
      rem <= rem_next;
    end
  end

  assign result = (neg && (rem != '0)) ? (side_q - rem) : rem;

endmodule

`default_nettype wire

// ===== hw/rtl/toroidal_grid_shape_placer_unit.sv =====
`default_nettype none

// Channel  | Direction | Handshake         | Payload
// in       | into      | in_valid/in_stall | op pos_x pos_y off_x off_y cell_value last_part
// out      | out of    | out_valid/out_stall | read_data land_done land_ok
// config   | into      | APB psel/penable  | grid_width (0x0), grid_height (0x4)
//
// After reset the grid is swept to zero, one cell a cycle, over all MAX_SIDE*MAX_SIDE
// cells, and no item is taken during the sweep. A write, a read or a landing part then
// passes the wrap units, which reduce both coordinates two bits a cycle. A final part
// that succeeds then writes each buffered part to the grid, as part reads and commit
// writes alternate. An item with a result holds in_stall high until the output is free.

module toroidal_grid_shape_placer_unit #(
  parameter int MAX_SIDE  = tgsp_pkg::DEF_MAX_SIDE,
  parameter int MAX_PARTS = tgsp_pkg::DEF_MAX_PARTS,
  parameter int CELL_BITS = tgsp_pkg::DEF_CELL_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [7:0]  off_x,
  input  wire logic signed [7:0]  off_y,
  input  wire logic [15:0] cell_value,
  input  wire logic        last_part,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      read_data,
  output logic             land_done,
  output logic             land_ok,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SIDE_BITS = $clog2(MAX_SIDE + 1);
  localparam int GRID_SIZE = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_BITS = $clog2(GRID_SIZE);
  localparam int PIDX_BITS = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CNT_BITS  = $clog2(MAX_PARTS + 1);
  localparam int PART_BITS = ADDR_BITS + CELL_BITS;
  localparam int PROD_BITS = 2 * SIDE_BITS + 1;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_WRAP   = 10'b0000000100,
    ST_ADDR   = 10'b0000001000,
    ST_ACCESS = 10'b0000010000,
    ST_RDWAIT = 10'b0000100000,
    ST_LCHECK = 10'b0001000000,
    ST_PREAD  = 10'b0010000000,
    ST_PWRITE = 10'b0100000000,
    ST_RESULT = 10'b1000000000
  } state_t;

  state_t state;

  logic [tgsp_pkg::REG_BITS-1:0] grid_width;
  logic [tgsp_pkg::REG_BITS-1:0] grid_height;
  logic [SIDE_BITS-1:0]          w_eff;
  logic [SIDE_BITS-1:0]          h_eff;

  tgsp_pkg::op_t          cur_op;
  logic [CELL_BITS-1:0]   cur_val;
  logic                   cur_last;
  logic [ADDR_BITS-1:0]   addr;
  logic [ADDR_BITS-1:0]   clr_addr;
  logic [CNT_BITS-1:0]    part_count;
  logic [CNT_BITS-1:0]    commit_idx;
  logic                   collision_seen;
  logic                   coll_next;
  logic [CNT_BITS-1:0]    count_next;

  logic [15:0]            res_data;
  logic                   res_done;
  logic                   res_ok;
  logic                   out_free;

  logic signed [tgsp_pkg::COORD_BITS-1:0] sum_x;
  logic signed [tgsp_pkg::COORD_BITS-1:0] sum_y;
  logic                   wrap_start;
  logic                   done_x;
  logic                   done_y;
  logic [SIDE_BITS-1:0]   rx;
  logic [SIDE_BITS-1:0]   ry;
  logic [PROD_BITS-1:0]   addr_full;

  logic                   g_we;
  logic [ADDR_BITS-1:0]   g_waddr;
  logic [CELL_BITS-1:0]   g_wdata;
  logic                   g_re;
  logic [CELL_BITS-1:0]   g_rdata;

  logic                   p_we;
  logic                   p_re;
  logic [PART_BITS-1:0]   p_rdata;

  logic                   cfg_wr;
  logic                   in_acc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      tgsp_pkg::REG_WIDTH:  prdata = 32'(grid_width);
      tgsp_pkg::REG_HEIGHT: prdata = 32'(grid_height);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= tgsp_pkg::SIDE_RESET;
      grid_height <= tgsp_pkg::SIDE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tgsp_pkg::REG_WIDTH:  grid_width  <= pwdata[tgsp_pkg::REG_BITS-1:0];
        tgsp_pkg::REG_HEIGHT: grid_height <= pwdata[tgsp_pkg::REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_width == '0) begin
      w_eff = SIDE_BITS'(1);
    end else if (32'(grid_width) > MAX_SIDE) begin
      w_eff = SIDE_BITS'(MAX_SIDE);
    end else begin
      w_eff = SIDE_BITS'(grid_width);
    end
    if (grid_height == '0) begin
      h_eff = SIDE_BITS'(1);
    end else if (32'(grid_height) > MAX_SIDE) begin
      h_eff = SIDE_BITS'(MAX_SIDE);
    end else begin
      h_eff = SIDE_BITS'(grid_height);
    end
  end

  assign in_stall   = (state != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign wrap_start = in_acc && (op != tgsp_pkg::OP_NONE);

  always_comb begin
    if (op == tgsp_pkg::OP_LAND) begin
      sum_x = tgsp_pkg::COORD_BITS'(pos_x) + tgsp_pkg::COORD_BITS'(off_x);
      sum_y = tgsp_pkg::COORD_BITS'(pos_y) + tgsp_pkg::COORD_BITS'(off_y);
    end else begin
      sum_x = tgsp_pkg::COORD_BITS'(pos_x);
      sum_y = tgsp_pkg::COORD_BITS'(pos_y);
    end
  end

  tgsp_wrap #(.SIDE_BITS(SIDE_BITS)) u_wrap_x (
    .clk    (clk),
    .rst    (rst),
    .start  (wrap_start),
    .value  (sum_x),
    .side   (w_eff),
    .done   (done_x),
    .result (rx)
  );

  tgsp_wrap #(.SIDE_BITS(SIDE_BITS)) u_wrap_y (
    .clk    (clk),
    .rst    (rst),
    .start  (wrap_start),
    .value  (sum_y),
    .side   (h_eff),
    .done   (done_y),
    .result (ry)
  );

  assign addr_full = PROD_BITS'(ry) * PROD_BITS'(w_eff) + PROD_BITS'(rx);

  assign coll_next  = collision_seen || (g_rdata != '0) ||
                      (32'(part_count) >= MAX_PARTS);
  assign count_next = (32'(part_count) < MAX_PARTS) ? (part_count + 1'b1) : part_count;

  always_comb begin
    g_we    = 1'b0;
    g_waddr = addr;
    g_wdata = cur_val;
    g_re    = 1'b0;
    p_we    = 1'b0;
    p_re    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_addr;
        g_wdata = '0;
      end
      ST_ACCESS: begin
        g_we = (cur_op == tgsp_pkg::OP_WRITE);
        g_re = (cur_op != tgsp_pkg::OP_WRITE);
      end
      ST_LCHECK: p_we = (32'(part_count) < MAX_PARTS);
      ST_PREAD:  p_re = 1'b1;
      ST_PWRITE: begin
        g_we    = 1'b1;
        g_waddr = p_rdata[PART_BITS-1:CELL_BITS];
        g_wdata = p_rdata[CELL_BITS-1:0];
      end
      default: ;
    endcase
  end

  tgsp_ram #(.WIDTH(CELL_BITS), .DEPTH(GRID_SIZE)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (g_re),
    .raddr (addr),
    .rdata (g_rdata)
  );

  tgsp_ram #(.WIDTH(PART_BITS), .DEPTH(MAX_PARTS)) u_parts (
    .clk   (clk),
    .we    (p_we),
    .waddr (part_count[PIDX_BITS-1:0]),
    .wdata ({addr, cur_val}),
    .re    (p_re),
    .raddr (commit_idx[PIDX_BITS-1:0]),
    .rdata (p_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      part_count     <= '0;
      collision_seen <= 1'b0;
      commit_idx     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if ((state == ST_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_BITS'(GRID_SIZE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (wrap_start) begin
            state <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (done_x && done_y) begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR: state <= ST_ACCESS;
        ST_ACCESS: begin
          unique case (cur_op)
            tgsp_pkg::OP_READ:  state <= ST_RDWAIT;
            tgsp_pkg::OP_LAND:  state <= ST_LCHECK;
            default:            state <= ST_IDLE;
          endcase
        end
        ST_RDWAIT: state <= ST_RESULT;
        ST_LCHECK: begin
          if (!cur_last) begin
            part_count     <= count_next;
            collision_seen <= coll_next;
            state          <= ST_IDLE;
          end else if (!coll_next) begin
            part_count <= count_next;
            commit_idx <= '0;
            state      <= ST_PREAD;
          end else begin
            part_count     <= '0;
            collision_seen <= 1'b0;
            state          <= ST_RESULT;
          end
        end
        ST_PREAD: state <= ST_PWRITE;
        ST_PWRITE: begin
          if (commit_idx + 1'b1 == part_count) begin
            part_count     <= '0;
            collision_seen <= 1'b0;
            state          <= ST_RESULT;
          end else begin
            commit_idx <= commit_idx + 1'b1;
            state      <= ST_PREAD;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_op   <= tgsp_pkg::op_t'(op);
      cur_val  <= CELL_BITS'(cell_value);
      cur_last <= last_part;
    end
    if (state == ST_ADDR) begin
      addr <= addr_full[ADDR_BITS-1:0];
    end
    if (state == ST_RDWAIT) begin
      res_data <= 16'(g_rdata);
      res_done <= 1'b0;
      res_ok   <= 1'b0;
    end
    if (state == ST_LCHECK) begin
      res_data <= '0;
      res_done <= 1'b1;
      res_ok   <= 1'b0;
    end
    if (state == ST_PWRITE) begin
      res_ok <= 1'b1;
    end
    if ((state == ST_RESULT) && out_free) begin
      read_data <= res_data;
      land_done <= res_done;
      land_ok   <= res_ok;
    end
  end

endmodule

`default_nettype wire
